[src/ilsi_pkg.sv]
package ilsi_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int CMD_W   = 3;
    localparam int IDX_W   = 5;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // list length needs to hold CAPACITY itself
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (LEN_W > IDX_W) ? LEN_W : IDX_W;

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [LEN_W-1:0]      t_len;
    typedef logic [CMP_W-1:0]      t_cmp;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_GET    = 3'd2,
        CMD_SET    = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // broadcast to every cell in the row
    typedef struct packed {
        logic  ins;
        logic  rem;
        logic  wr;
        t_cmp  idx;
        t_cmp  len;
        t_data val;
    } t_op;

endpackage

[src/ilsi_cmd_if.sv]
interface ilsi_cmd_if
    import ilsi_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [IDX_W-1:0]   index;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output command, output index, output value, input ready);
    modport sink   (input valid, input command, input index, input value, output ready);
endinterface

[src/ilsi_rsp_if.sv]
interface ilsi_rsp_if
    import ilsi_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output status, output read_value, output count, input ready);
    modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

[src/indexed_list_with_shift_insert_core.sv]
// channel  | dir | beat contents
// i_cmd    | in  | command, index, value
// o_rsp    | out | status, read_value, count
//
// one command per cycle while o_rsp is not stalled: every cell shifts or loads in the same edge
// a response appears in the cycle after its command beat and is held in an
// output register; a new command is taken while o_rsp is empty or drained
// reset empties the list at once; element storage itself is not cleared
// backpressure on o_rsp stalls i_cmd through ready
module indexed_list_with_shift_insert_core
    import ilsi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    ilsi_cmd_if.sink           i_cmd,
    ilsi_rsp_if.source         o_rsp
);

    t_len    r_len;
    t_len    n_len;
    logic    r_valid;
    t_status r_status;
    t_status n_status;
    t_data   r_read;
    t_data   n_read;
    t_op     op;
    logic    accept;
    t_cmp    idx_c;
    t_cmp    len_c;
    t_data   read_or;

    t_data   cell_data [CAPACITY];
    t_data   cell_hit  [CAPACITY];

    assign i_cmd.ready = i_rst_n && (!r_valid || o_rsp.ready);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign idx_c       = t_cmp'(i_cmd.index);
    assign len_c       = t_cmp'(r_len);

    always_comb begin
        read_or = '0;
        for (int p = 0; p < CAPACITY; p++) begin
            read_or = read_or | cell_hit[p];
        end
    end

    always_comb begin
        n_len    = r_len;
        n_status = ST_OK;
        n_read   = '0;
        op.ins   = 1'b0;
        op.rem   = 1'b0;
        op.wr    = 1'b0;
        op.idx   = idx_c;
        op.len   = len_c;
        op.val   = t_data'(i_cmd.value);
        unique case (t_cmd'(i_cmd.command))
            CMD_INSERT: begin
                if (idx_c > len_c) begin
                    n_status = ST_RANGE;
                end else if (r_len == t_len'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    op.ins = accept;
                    n_len  = r_len + t_len'(1);
                end
            end
            CMD_REMOVE: begin
                if (idx_c >= len_c) begin
                    n_status = ST_RANGE;
                end else begin
                    op.rem = accept;
                    n_len  = r_len - t_len'(1);
                end
            end
            CMD_GET: begin
                if (idx_c >= len_c) begin
                    n_status = ST_RANGE;
                end else begin
                    n_read = read_or;
                end
            end
            CMD_SET: begin
                if (idx_c >= len_c) begin
                    n_status = ST_RANGE;
                end else begin
                    op.wr = accept;
                end
            end
            CMD_CLEAR: begin
                n_len = '0;
            end
            default: begin
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_data left_in;
        t_data right_in;
        if (g == 0) begin : g_first
            assign left_in = '0;
        end else begin : g_mid_l
            assign left_in = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_mid_r
            assign right_in = cell_data[g+1];
        end
        ilsi_cell u_cell (
            .i_clk   (i_clk),
            .i_pos   (t_cmp'(g)),
            .i_op    (op),
            .i_left  (left_in),
            .i_right (right_in),
            .o_data  (cell_data[g]),
            .o_hit   (cell_hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_len   <= n_len;
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_read   <= n_read;
        end
    end

    assign o_rsp.valid      = r_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.read_value = VALUE_W'(r_read);
    assign o_rsp.count      = COUNT_W'(r_len);

endmodule

[src/ilsi_cell.sv]
module ilsi_cell
    import ilsi_pkg::*;
(
    input  logic  i_clk,
    input  t_cmp  i_pos,
    input  t_op   i_op,
    input  t_data i_left,
    input  t_data i_right,
    output t_data o_data,
    output t_data o_hit
);

    t_data r_data;
    t_data n_data;
    logic  hit;
    t_cmp  pos_nxt;

    always_comb begin
        hit     = (i_pos == i_op.idx);
        pos_nxt = i_pos + t_cmp'(1);
        n_data  = r_data;
        if (i_op.ins) begin
            if (hit) begin
                n_data = i_op.val;
            end else if (i_pos > i_op.idx && i_pos <= i_op.len) begin
                n_data = i_left;
            end
        end else if (i_op.rem) begin
            // entries above the removed one slide down
            if (i_pos >= i_op.idx && pos_nxt < i_op.len) begin
                n_data = i_right;
            end
        end else if (i_op.wr) begin
            if (hit) begin
                n_data = i_op.val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_hit  = hit ? r_data : '0;

endmodule
